// ===== sv/two_class_strict_priority_queue_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the two-class strict-priority queue unit
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_STRICT_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define TWO_CLASS_STRICT_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define TCSPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define TCSPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

// ===== sv/tcspq_pkg.sv =====
// ----------------------------------------------------------------------------
// tcspq_pkg
// Types and fixed field widths shared by the strict-priority queue unit.
// ----------------------------------------------------------------------------
package tcspq_pkg;

  localparam int unsigned TagPortW = 16;
  localparam int unsigned CountW   = 5;
  localparam int unsigned StatusW  = 3;

  typedef enum logic [StatusW-1:0] {
    ST_ENQUEUED   = 3'd0,
    ST_SERVED_PRI = 3'd1,
    ST_SERVED_NRM = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_FULL       = 3'd4
  } status_e;

  // Commands from the control logic to one ring.
  typedef struct packed {
    logic push;
    logic pop;
  } ring_cmd_t;

  // Occupancy flags from one ring.
  typedef struct packed {
    logic empty;
    logic full;
  } ring_flags_t;

endpackage

// ===== sv/tcspq_ring.sv =====
// ----------------------------------------------------------------------------
// tcspq_ring
// One circular FIFO: a synchronous memory with head, tail and fill registers.
// ----------------------------------------------------------------------------
`include "two_class_strict_priority_queue_unit_macros.svh"

module tcspq_ring #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned TAG_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcspq_pkg::ring_cmd_t          cmd_i,
  input  logic [TAG_WIDTH-1:0]          wr_data_i,
  output logic [TAG_WIDTH-1:0]          rd_data_o,
  output logic [$clog2(DEPTH+1)-1:0]    fill_o,
  output tcspq_pkg::ring_flags_t        flags_o
);
  import tcspq_pkg::*;

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned FillW = $clog2(DEPTH+1);

  logic [TAG_WIDTH-1:0] mem [DEPTH];
  logic [TAG_WIDTH-1:0] rd_q;
  logic [AddrW-1:0]     head_q, head_d;
  logic [AddrW-1:0]     tail_q, tail_d;
  logic [FillW-1:0]     fill_q, fill_d;

  assign flags_o.empty = (fill_q == '0);
  assign flags_o.full  = (fill_q == FillW'(DEPTH));
  assign fill_o        = fill_q;
  assign rd_data_o     = rd_q;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (cmd_i.push) begin
      tail_d = (tail_q == AddrW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
    end
    if (cmd_i.pop) begin
      head_d = (head_q == AddrW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
    end
    unique case ({cmd_i.push, cmd_i.pop})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  // Storage and registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[tail_q] <= wr_data_i;
    end
    if (cmd_i.pop) begin
      rd_q <= mem[head_q];
    end
  end

  `TCSPQ_ASSERT_SAME(a_no_push_full, clk_i, rst_ni, cmd_i.push, !flags_o.full)
  `TCSPQ_ASSERT_SAME(a_no_pop_empty, clk_i, rst_ni, cmd_i.pop, !flags_o.empty)
  `TCSPQ_ASSERT_NEXT(a_pop_drops_fill, clk_i, rst_ni, cmd_i.pop && !cmd_i.push, fill_q == $past(fill_q) - 1'b1)

endmodule

// ===== sv/two_class_strict_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// two_class_strict_priority_queue_unit
// Two tag FIFOs, priority and normal, served under strict priority.
// ----------------------------------------------------------------------------
// Each transaction either enqueues a tag into the queue that its class names
// or serves the oldest waiting tag, taking from the priority queue whenever it
// holds anything and from the normal queue otherwise. The block accepts one
// transaction in every clock cycle and busy_o stays low: a transaction is taken
// at any edge with start_i high, and its result appears on the result ports,
// marked by done_o, in the very next cycle, so the throughput is one
// transaction per cycle. The registered read port of the queue memories,
// which a serve reads at the head address in the accepting cycle, holds the
// served tag. The receiver cannot stall: each result is shown for exactly one
// cycle and must be captured then. An enqueue to a full queue drops its tag
// and reports a full status; a serve with both queues empty reports that
// nothing is waiting. The reported counts are the fill levels after the
// transaction, in their low five bits.
// ----------------------------------------------------------------------------
`include "two_class_strict_priority_queue_unit_macros.svh"

module two_class_strict_priority_queue_unit #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned TAG_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              operation_i,
  input  logic                              priority_class_i,
  input  logic [tcspq_pkg::TagPortW-1:0]    item_tag_i,
  output logic                              done_o,
  output logic [tcspq_pkg::StatusW-1:0]     status_o,
  output logic [tcspq_pkg::TagPortW-1:0]    served_tag_o,
  output logic [tcspq_pkg::CountW-1:0]      priority_count_o,
  output logic [tcspq_pkg::CountW-1:0]      normal_count_o
);
  import tcspq_pkg::*;

  localparam int unsigned FillW = $clog2(DEPTH+1);

  logic                 accept;
  logic [TAG_WIDTH-1:0] wr_tag;
  ring_cmd_t            pri_cmd, nrm_cmd;
  ring_flags_t          pri_flags, nrm_flags;
  logic [TAG_WIDTH-1:0] pri_rd, nrm_rd;
  logic [FillW-1:0]     pri_fill, nrm_fill;
  status_e              status_d, status_q;
  logic                 done_q;

  // The unit never holds off a transaction, so busy_o is tied low.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Tags are kept to the storage width of the queues.
  assign wr_tag = TAG_WIDTH'(item_tag_i);

  // Decode the transaction into ring commands. A serve pops the priority
  // queue when it is not empty and falls back to the normal queue.
  always_comb begin
    pri_cmd  = '0;
    nrm_cmd  = '0;
    status_d = ST_EMPTY;
    priority if (!operation_i) begin
      if (!priority_class_i) begin
        pri_cmd.push = accept && !pri_flags.full;
        status_d     = pri_flags.full ? ST_FULL : ST_ENQUEUED;
      end else begin
        nrm_cmd.push = accept && !nrm_flags.full;
        status_d     = nrm_flags.full ? ST_FULL : ST_ENQUEUED;
      end
    end else if (!pri_flags.empty) begin
      pri_cmd.pop = accept;
      status_d    = ST_SERVED_PRI;
    end else if (!nrm_flags.empty) begin
      nrm_cmd.pop = accept;
      status_d    = ST_SERVED_NRM;
    end else begin
      status_d    = ST_EMPTY;
    end
  end

  tcspq_ring #(
    .DEPTH     (DEPTH),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_pri_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (pri_cmd),
    .wr_data_i (wr_tag),
    .rd_data_o (pri_rd),
    .fill_o    (pri_fill),
    .flags_o   (pri_flags)
  );

  tcspq_ring #(
    .DEPTH     (DEPTH),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_nrm_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (nrm_cmd),
    .wr_data_i (wr_tag),
    .rd_data_o (nrm_rd),
    .fill_o    (nrm_fill),
    .flags_o   (nrm_flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      status_q <= ST_ENQUEUED;
    end else begin
      done_q <= accept;
      if (accept) begin
        status_q <= status_d;
      end
    end
  end

  // The ring read registers hold the served tag during the result cycle, and
  // the fill registers already hold the levels after the transaction; a new
  // transaction accepted in that cycle only changes them at its closing edge.
  always_comb begin
    unique case (status_q)
      ST_SERVED_PRI: served_tag_o = TagPortW'(pri_rd);
      ST_SERVED_NRM: served_tag_o = TagPortW'(nrm_rd);
      default:       served_tag_o = '0;
    endcase
  end

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign priority_count_o = CountW'(pri_fill);
  assign normal_count_o   = CountW'(nrm_fill);

  `TCSPQ_ASSERT_SAME(a_single_pop, clk_i, rst_ni, pri_cmd.pop, !nrm_cmd.pop)
  `TCSPQ_ASSERT_NEXT(a_result_follows, clk_i, rst_ni, accept, done_o)
  `TCSPQ_ASSERT_SAME(a_tag_only_on_serve, clk_i, rst_ni, done_o && (served_tag_o != '0), (status_o == ST_SERVED_PRI) || (status_o == ST_SERVED_NRM))

endmodule

// ===== tb/sv/tcspq_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench codes for the strict-priority queue unit
// Names for the operation and class input codes that the stimulus and the
// checker both decode.
// ----------------------------------------------------------------------------
package tcspq_tb_pkg;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_SERVE   = 1'b1
  } queue_op_e;

  typedef enum logic {
    CLASS_PRIORITY = 1'b0,
    CLASS_NORMAL   = 1'b1
  } queue_class_e;

endpackage

// ===== tb/sv/tcspq_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Result checker for the strict-priority queue unit
// Mirrors both tag rings, predicts the result of every accepted transaction
// and compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module tcspq_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic                           operation_i,
  input  logic                           priority_class_i,
  input  logic [tcspq_pkg::TagPortW-1:0] item_tag_i,
  input  logic                           done_i,
  input  logic [tcspq_pkg::StatusW-1:0]  status_i,
  input  logic [tcspq_pkg::TagPortW-1:0] served_tag_i,
  input  logic [tcspq_pkg::CountW-1:0]   priority_count_i,
  input  logic [tcspq_pkg::CountW-1:0]   normal_count_i,
  output int unsigned                    errors_o,
  output int unsigned                    pending_o,
  output int unsigned                    results_o,
  output int unsigned                    drops_o,
  output int unsigned                    empty_serves_o
);

  import tcspq_pkg::*;
  import tcspq_tb_pkg::*;

  localparam int unsigned RingDepth = 16;

  typedef struct {
    status_e             status;
    logic [TagPortW-1:0] tag;
    logic [CountW-1:0]   pri_count;
    logic [CountW-1:0]   nrm_count;
  } queue_result_t;

  // Mirror of the two rings.
  logic [TagPortW-1:0] pri_ring [RingDepth];
  logic [TagPortW-1:0] nrm_ring [RingDepth];
  logic [3:0]          pri_rd, pri_wr, nrm_rd, nrm_wr;
  logic [4:0]          pri_fill, nrm_fill;

  queue_result_t predicted_results[$];
  int unsigned   mismatch_count;
  int unsigned   result_count;
  int unsigned   drop_count;
  int unsigned   empty_count;

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_count++;
    $display("[%0t] mismatch on result %0d: %s is 0x%0h, expected 0x%0h",
             $realtime, result_count, field, got, want);
  endtask

  // Applies one transaction to the mirrored rings and returns its result.
  function automatic queue_result_t arbitrate_item(input queue_op_e op,
                                                   input queue_class_e cls,
                                                   input logic [TagPortW-1:0] tag);
    queue_result_t r;
    r.tag = '0;
    if (op == OP_ENQUEUE) begin
      if (cls == CLASS_PRIORITY) begin
        if (pri_fill == RingDepth) begin
          r.status = ST_FULL;
        end else begin
          pri_ring[pri_wr] = tag;
          pri_wr++;
          pri_fill++;
          r.status = ST_ENQUEUED;
        end
      end else begin
        if (nrm_fill == RingDepth) begin
          r.status = ST_FULL;
        end else begin
          nrm_ring[nrm_wr] = tag;
          nrm_wr++;
          nrm_fill++;
          r.status = ST_ENQUEUED;
        end
      end
    end else if (pri_fill != 0) begin
      r.tag = pri_ring[pri_rd];
      pri_rd++;
      pri_fill--;
      r.status = ST_SERVED_PRI;
    end else if (nrm_fill != 0) begin
      r.tag = nrm_ring[nrm_rd];
      nrm_rd++;
      nrm_fill--;
      r.status = ST_SERVED_NRM;
    end else begin
      r.status = ST_EMPTY;
    end
    r.pri_count = pri_fill;
    r.nrm_count = nrm_fill;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want;
    if (!rst_ni) begin
      pri_rd = '0;
      pri_wr = '0;
      nrm_rd = '0;
      nrm_wr = '0;
      pri_fill = '0;
      nrm_fill = '0;
      predicted_results.delete();
      mismatch_count = 0;
      result_count = 0;
      drop_count = 0;
      empty_count = 0;
      errors_o <= 0;
      pending_o <= 0;
      results_o <= 0;
      drops_o <= 0;
      empty_serves_o <= 0;
    end else begin
      // A result strobed now belongs to an earlier transaction, so it is
      // checked before the transaction accepted at this edge is predicted.
      if (done_i === 1'b1) begin
        if (predicted_results.size() == 0) begin
          mismatch_count++;
          $display("[%0t] result strobed with no transaction outstanding", $realtime);
        end else begin
          want = predicted_results.pop_front();
          if (status_i !== want.status)
            report_mismatch("status", status_i, want.status);
          if (served_tag_i !== want.tag)
            report_mismatch("served_tag", served_tag_i, want.tag);
          if (priority_count_i !== want.pri_count)
            report_mismatch("priority_count", priority_count_i, want.pri_count);
          if (normal_count_i !== want.nrm_count)
            report_mismatch("normal_count", normal_count_i, want.nrm_count);
          if (want.status == ST_FULL) drop_count++;
          if (want.status == ST_EMPTY) empty_count++;
          result_count++;
        end
      end
      if (start_i && !busy_i) begin
        predicted_results.push_back(arbitrate_item(queue_op_e'(operation_i),
                                                   queue_class_e'(priority_class_i),
                                                   item_tag_i));
      end
      errors_o <= mismatch_count;
      pending_o <= predicted_results.size();
      results_o <= result_count;
      drops_o <= drop_count;
      empty_serves_o <= empty_count;
    end
  end

endmodule

// ===== tb/sv/two_class_strict_priority_queue_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the two-class strict-priority queue unit
// Drives enqueue and serve transactions, first a directed set and then
// several random phases with different sender idling and queue pressure,
// while a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module two_class_strict_priority_queue_unit_tb;

  import tcspq_pkg::*;
  import tcspq_tb_pkg::*;

  // The cycle limit only catches a hang.
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned PhaseCount    = 4;
  localparam int unsigned ItemsPerPhase = 100;

  // All inputs of the block start at known values.
  logic                  clk_i            = 1'b0;
  logic                  rst_ni           = 1'b0;
  logic                  start_i          = 1'b0;
  logic                  operation_i      = 1'b0;
  logic                  priority_class_i = 1'b0;
  logic [TagPortW-1:0]   item_tag_i       = '0;

  logic                  busy_o;
  logic                  done_o;
  logic [StatusW-1:0]    status_o;
  logic [TagPortW-1:0]   served_tag_o;
  logic [CountW-1:0]     priority_count_o;
  logic [CountW-1:0]     normal_count_o;

  int unsigned           error_total;
  int unsigned           outstanding;
  int unsigned           results_seen;
  int unsigned           drops_seen;
  int unsigned           empty_serves_seen;
  int unsigned           cycle_count = 0;
  int unsigned           sent_count  = 0;

  // Sender idle percentage per random phase. The third phase would have been
  // the receiver-stall phase, but results cannot be held off, so it runs at
  // full rate. The enqueue share moves the rings through full and empty.
  int unsigned idle_pct [PhaseCount] = '{0, 48, 0, 38};
  int unsigned enq_pct  [PhaseCount] = '{88, 50, 70, 20};

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  two_class_strict_priority_queue_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .operation_i      (operation_i),
    .priority_class_i (priority_class_i),
    .item_tag_i       (item_tag_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .served_tag_o     (served_tag_o),
    .priority_count_o (priority_count_o),
    .normal_count_o   (normal_count_o)
  );

  tcspq_result_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_i           (busy_o),
    .operation_i      (operation_i),
    .priority_class_i (priority_class_i),
    .item_tag_i       (item_tag_i),
    .done_i           (done_o),
    .status_i         (status_o),
    .served_tag_i     (served_tag_o),
    .priority_count_i (priority_count_o),
    .normal_count_i   (normal_count_o),
    .errors_o         (error_total),
    .pending_o        (outstanding),
    .results_o        (results_seen),
    .drops_o          (drops_seen),
    .empty_serves_o   (empty_serves_seen)
  );

  // Watchdog: a run that hangs is reported as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, outstanding);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Presents one transaction and returns at the edge that accepts it. Start
  // is left high, so a following transaction goes out back to back without
  // the strobe being lowered and raised in the same time step.
  task automatic send_transaction(input queue_op_e op, input queue_class_e cls,
                                  input logic [TagPortW-1:0] tag);
    start_i          <= 1'b1;
    operation_i      <= op;
    priority_class_i <= cls;
    item_tag_i       <= tag;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sent_count++;
  endtask

  // Random sender gaps: each cycle idles with the given chance.
  task automatic sender_gap(input int unsigned pct);
    while ($urandom_range(99) < pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Holds the sender off until every outstanding result has come back. The
  // checker publishes its count through a register, so an idle edge comes first.
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin
    queue_op_e    op;
    queue_class_e cls;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A serve on two empty rings comes first, with the class
    // and tag fields set to values that must be ignored. Then the extreme
    // tags go into both rings, and the serves show that the priority ring is
    // emptied before the normal ring is touched, in arrival order.
    send_transaction(OP_SERVE, CLASS_NORMAL, 16'hFFFF);
    send_transaction(OP_SERVE, CLASS_PRIORITY, 16'h0000);
    send_transaction(OP_ENQUEUE, CLASS_NORMAL, 16'hFFFF);
    send_transaction(OP_ENQUEUE, CLASS_NORMAL, 16'h0000);
    send_transaction(OP_ENQUEUE, CLASS_PRIORITY, 16'h0000);
    send_transaction(OP_ENQUEUE, CLASS_PRIORITY, 16'hFFFF);
    send_transaction(OP_SERVE, CLASS_NORMAL, 16'hA5A5);
    send_transaction(OP_ENQUEUE, CLASS_PRIORITY, 16'h5A5A);
    send_transaction(OP_SERVE, CLASS_PRIORITY, 16'h1234);
    send_transaction(OP_SERVE, CLASS_NORMAL, 16'hFFFF);
    send_transaction(OP_SERVE, CLASS_PRIORITY, 16'h0000);
    send_transaction(OP_SERVE, CLASS_NORMAL, 16'h8001);
    send_transaction(OP_SERVE, CLASS_PRIORITY, 16'h7FFE);
    drain_results();

    // Random phases. Heavy enqueue phases push both rings into the full
    // case, which drops tags; the serve-heavy phase drains them and then
    // keeps hitting the empty case. Serve transactions still carry random
    // class and tag values, which the block must ignore.
    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        op  = ($urandom_range(99) < enq_pct[phase]) ? OP_ENQUEUE : OP_SERVE;
        cls = queue_class_e'($urandom_range(1));
        sender_gap(idle_pct[phase]);
        send_transaction(op, cls, TagPortW'($urandom_range(16'hFFFF)));
      end
      drain_results();
    end

    // Idle edges after the drain catch stray result strobes.
    repeat (4) @(posedge clk_i);

    $display("Sent %0d transactions in a directed set and %0d random phases.",
             sent_count, PhaseCount);
    $display("Checked %0d results, including %0d full drops and %0d empty serves.",
             results_seen, drops_seen, empty_serves_seen);
    if (error_total == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
